// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the synth datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- rtl/core/hws_pkg.sv -----
// Types and constants for the harmonic waveform synth
`timescale 1ns / 1ps
`default_nettype none
package hws_pkg;
   localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] REG_DC_OFFSET   = 2'd1;
   localparam logic [1:0] REG_COUNT       = 2'd2;
   localparam logic [1:0] REG_MODE        = 2'd3;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_GEN  = 1'b1;

   // odd Taylor coefficients of sin(pi*x/2), Q30
   function automatic logic [30:0] sin_coef(input logic [2:0] k);
      logic [30:0] c;
      case (k)
         3'd0: c = 31'd1686629713;
         3'd1: c = 31'd693598669;
         3'd2: c = 31'd85569306;
         3'd3: c = 31'd5026994;
         3'd4: c = 31'd172272;
         3'd5: c = 31'd3864;
         default: c = '0;
      endcase
      return c;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_DIV1, ST_DIV2, ST_FETCH, ST_X2, ST_HORN,
      ST_SIN, ST_MAG, ST_TERM, ST_ACC, ST_SAT
   } state_type;

   typedef struct packed {
      logic init;      // latch sample, preset sum to DC offset, harmonic 0
      logic prod;      // freq*n product
      logic div_start; // start remainder/quotient division
      logic fetch;     // read phase, build x
      logic x2;
      logic horn;      // one Horner step
      logic sin_s;
      logic mag;
      logic term;
      logic acc;       // add term, next harmonic
      logic finish;    // saturate and emit
      logic load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic horn_last;
      logic harm_last;
      logic none;      // no harmonics to sum
   } status_type;
endpackage
`default_nettype wire

// ----- rtl/core/harmonic_waveform_synth.sv -----
// Top level of the harmonic waveform synth
// Load transaction: no result, busy stays low. Generate transaction, K = harmonics summed:
// result strobed once the DC offset and K terms are summed and saturated; per harmonic a 56-step
// bit-serial divider for the phase, 5 Horner steps on one shared multiplier, 8 other steps.
// Next transaction is taken at the earliest on the edge that takes the result strobe.
// Synchronous reset: sample_rate 4000, other registers and table valid bits 0.
`timescale 1ns / 1ps
`default_nettype none
module harmonic_waveform_synth #(
   parameter int MAX_HARMONICS = 16,
   parameter int SINE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_action,
   input  wire logic [3:0]         req_harmonic_slot,
   input  wire logic [23:0]        req_harmonic_freq,
   input  wire logic [15:0]        req_harmonic_phase,
   input  wire logic signed [31:0] req_harmonic_amp,
   input  wire logic [15:0]        req_sample_index,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_sample_value,
   output logic [15:0]             rsp_index_echo,
   output logic                    rsp_saturated
);
   import hws_pkg::*;
   cmd_type cmd;
   status_type stat;
   logic go;
   // a transaction is taken only while idle
   assign go = start && !busy;

   hws_ctrl u_ctrl (.clock, .reset, .start(go), .action(req_action), .stat, .busy, .cmd);

   hws_datapath #(.MAX_HARMONICS(MAX_HARMONICS), .SINE_BITS(SINE_BITS)) u_dp (
      .clock, .reset, .cmd, .stat, .csr_write, .csr_index, .csr_data,
      .req_harmonic_slot, .req_harmonic_freq, .req_harmonic_phase,
      .req_harmonic_amp, .req_sample_index, .rsp_valid, .rsp_sample_value,
      .rsp_index_echo, .rsp_saturated);
endmodule
`default_nettype wire

// ----- rtl/core/hws_ctrl.sv -----
// Sequencer for the harmonic waveform synth
`timescale 1ns / 1ps
`default_nettype none
module hws_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               action,
   input  wire hws_pkg::status_type stat,
   output logic                    busy,
   output hws_pkg::cmd_type        cmd
);
   import hws_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start && action == ACT_GEN) state_in = ST_PROD;
         ST_PROD:  state_in = stat.none ? ST_SAT : ST_DIV1;
         ST_DIV1:  state_in = ST_DIV2;
         ST_DIV2:  if (stat.div_done) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_X2;
         ST_X2:    state_in = ST_HORN;
         ST_HORN:  if (stat.horn_last) state_in = ST_SIN;
         ST_SIN:   state_in = ST_MAG;
         ST_MAG:   state_in = ST_TERM;
         ST_TERM:  state_in = ST_ACC;
         ST_ACC:   state_in = stat.harm_last ? ST_SAT : ST_PROD;
         ST_SAT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.init = start && action == ACT_GEN;
            cmd.load = start && action == ACT_LOAD;
         end
         ST_PROD:  cmd.prod = 1'b1;
         ST_DIV1:  cmd.div_start = 1'b1;
         ST_FETCH: cmd.fetch = 1'b1;
         ST_X2:    cmd.x2 = 1'b1;
         ST_HORN:  cmd.horn = 1'b1;
         ST_SIN:   cmd.sin_s = 1'b1;
         ST_MAG:   cmd.mag = 1'b1;
         ST_TERM:  cmd.term = 1'b1;
         ST_ACC:   cmd.acc = 1'b1;
         ST_SAT:   cmd.finish = 1'b1;
         default:  ;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/core/hws_datapath.sv -----
// Datapath: harmonic table, phase division, sine polynomial, accumulator
`timescale 1ns / 1ps
`default_nettype none
module hws_datapath #(
   parameter int MAX_HARMONICS = 16,
   parameter int SINE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hws_pkg::cmd_type   cmd,
   output hws_pkg::status_type     stat,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic [3:0]         req_harmonic_slot,
   input  wire logic [23:0]        req_harmonic_freq,
   input  wire logic [15:0]        req_harmonic_phase,
   input  wire logic signed [31:0] req_harmonic_amp,
   input  wire logic [15:0]        req_sample_index,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_sample_value,
   output logic [15:0]             rsp_index_echo,
   output logic                    rsp_saturated
);
   import hws_pkg::*;
   localparam int HW = $clog2(MAX_HARMONICS + 1);
   localparam int IW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam logic [SINE_BITS-1:0] FULL = {1'b0, {(SINE_BITS-1){1'b1}}};

   logic [15:0] rate_ff;
   logic signed [31:0] dc_ff;
   logic [4:0] count_ff;
   logic mode_ff;
   logic [MAX_HARMONICS-1:0] valid_ff;
   logic [23:0] freq_mem [MAX_HARMONICS];
   logic [15:0] phase_mem [MAX_HARMONICS];
   logic signed [31:0] amp_mem [MAX_HARMONICS];

   logic [HW-1:0] k_ff, lim_ff;
   logic [15:0] n_ff;
   logic [23:0] d_ff;
   logic [39:0] prod_ff;
   logic [23:0] frd_ff; logic [15:0] phd_ff; logic signed [31:0] ampd_ff;
   // restoring divider: 40 bits remainder, then 16 fraction bits
   logic [5:0] dcnt_ff;
   logic [24:0] rem_ff;
   logic [39:0] dsh_ff;
   logic [15:0] quo_ff;
   logic div_run_ff;
   logic [1:0] quad_ff;
   logic [30:0] x_ff, x2_ff, t_ff, s_ff;
   logic [2:0] hk_ff;
   logic [SINE_BITS-1:0] mag_ff;
   logic signed [31+SINE_BITS:0] p_ff;
   logic signed [37:0] sum_ff;

   // config and table
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 16'd4000; dc_ff <= '0; count_ff <= '0; mode_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_SAMPLE_RATE: rate_ff <= csr_data[15:0];
               REG_DC_OFFSET:   dc_ff <= csr_data;
               REG_COUNT:       count_ff <= csr_data[4:0];
               REG_MODE:        mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.load && 32'(req_harmonic_slot) < MAX_HARMONICS)
            valid_ff[IW'(req_harmonic_slot)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && 32'(req_harmonic_slot) < MAX_HARMONICS) begin
         freq_mem[IW'(req_harmonic_slot)] <= req_harmonic_freq;
         phase_mem[IW'(req_harmonic_slot)] <= req_harmonic_phase;
         amp_mem[IW'(req_harmonic_slot)] <= req_harmonic_amp;
      end
      if (cmd.init || cmd.acc) begin
         frd_ff <= freq_mem[IW'(cmd.init ? '0 : k_ff + 1'b1)];
         phd_ff <= phase_mem[IW'(cmd.init ? '0 : k_ff + 1'b1)];
         ampd_ff <= amp_mem[IW'(cmd.init ? '0 : k_ff + 1'b1)];
      end
   end

   logic vk;
   assign vk = valid_ff[IW'(k_ff)];
   logic [24:0] trial;
   assign trial = {rem_ff[23:0], dsh_ff[39]} - {1'b0, d_ff};

   logic [15:0] ph;
   logic [13:0] m;
   logic [61:0] mul;
   logic [15:0] frac;
   always_comb begin
      frac = quo_ff + (vk ? phd_ff : 16'd0);
      ph = mode_ff ? frac + 16'd16384 : frac;
      m = ph[13:0];
      mul = '0;
      if (cmd.x2) mul = x_ff * x_ff;
      else if (cmd.horn) mul = x2_ff * t_ff;
      else if (cmd.sin_s) mul = x_ff * t_ff;
   end

   logic [SINE_BITS+31:0] mraw;
   assign mraw = (s_ff * FULL + 48'(1 << 29)) >> 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0; rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.finish;
         if (cmd.div_start) div_run_ff <= 1'b1;
         else if (div_run_ff && dcnt_ff == 6'd55) div_run_ff <= 1'b0;
      end
      if (cmd.init) begin
         n_ff <= req_sample_index;
         d_ff <= {(rate_ff == 0 ? 16'd1 : rate_ff), 8'd0};
         lim_ff <= (count_ff > MAX_HARMONICS) ? HW'(MAX_HARMONICS) : HW'(count_ff);
         k_ff <= '0;
         sum_ff <= 38'(dc_ff);
      end
      if (cmd.prod) prod_ff <= (vk ? frd_ff : 24'd0) * n_ff;
      if (cmd.div_start) begin
         rem_ff <= '0; dsh_ff <= prod_ff; dcnt_ff <= '0; quo_ff <= '0;
      end else if (div_run_ff) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         dsh_ff <= {dsh_ff[38:0], 1'b0};
         if (!trial[24]) rem_ff <= trial;
         else rem_ff <= {rem_ff[23:0], dsh_ff[39]};
         if (dcnt_ff >= 6'd40) quo_ff <= {quo_ff[14:0], ~trial[24]};
      end
      if (cmd.fetch) begin
         if (!vk) quo_ff <= '0;
         quad_ff <= ph[15:14];
         x_ff <= {(ph[14] ? 15'd16384 - {1'b0, m} : {1'b0, m}), 16'd0};
      end
      if (cmd.x2) begin x2_ff <= 31'(mul >> 30); t_ff <= sin_coef(3'd5); hk_ff <= 3'd4; end
      if (cmd.horn) begin
         t_ff <= sin_coef(hk_ff) - 31'(mul >> 30);
         hk_ff <= hk_ff - 1'b1;
      end
      if (cmd.sin_s) s_ff <= 31'(mul >> 30);
      if (cmd.mag) mag_ff <= (mraw > FULL) ? FULL : SINE_BITS'(mraw);
      if (cmd.term) p_ff <= (vk ? ampd_ff : 32'sd0) * $signed({1'b0, mag_ff});
      if (cmd.acc) begin
         if (quad_ff[1])
            sum_ff <= sum_ff + 38'((-p_ff + (1 <<< (SINE_BITS-2))) >>> (SINE_BITS-1));
         else
            sum_ff <= sum_ff + 38'((p_ff + (1 <<< (SINE_BITS-2))) >>> (SINE_BITS-1));
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.finish) begin
         rsp_index_echo <= n_ff;
         if (sum_ff > 38'sd2147483647) begin
            rsp_sample_value <= 32'sh7fffffff; rsp_saturated <= 1'b1;
         end else if (sum_ff < -38'sd2147483648) begin
            rsp_sample_value <= 32'sh80000000; rsp_saturated <= 1'b1;
         end else begin
            rsp_sample_value <= 32'(sum_ff); rsp_saturated <= 1'b0;
         end
      end
   end

   assign stat.div_done = div_run_ff && dcnt_ff == 6'd55;
   assign stat.horn_last = (hk_ff == 3'd0);
   assign stat.harm_last = (k_ff + 1'b1 >= lim_ff);
   assign stat.none = (lim_ff == '0);

   `include "assert_macros.svh"
   `ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPL(a_k_range, clock, reset, cmd.acc, k_ff < lim_ff)
   `ASSERT_IMPL(a_div_idle, clock, reset, cmd.fetch, !div_run_ff)
endmodule
`default_nettype wire
